// ===== hw/rtl/fsa_pkg.sv =====
// Package for the fit segment allocator: sizes, codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package fsa_pkg;
    localparam int MaxSegments = 64;
    localparam int IdxW  = $clog2(MaxSegments);
    localparam int CntW  = $clog2(MaxSegments + 1);
    localparam int SizeW = 22;
    localparam int PidW  = 16;
    localparam int ReqW  = 16;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_NOOWNER = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        STRAT_FIRST = 2'd0,
        STRAT_BEST  = 2'd1,
        STRAT_WORST = 2'd2
    } strat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SCAN_LAST,
        S_DECIDE,
        S_SHIFT,
        S_SPLIT,
        S_MARK,
        S_FREE_SCAN,
        S_FREE_LAST,
        S_REWIND,
        S_MERGE,
        S_MERGE_LAST,
        S_FLUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clr_ptr;     // reset read/write pointers
        logic scan;        // advance allocation scan
        logic scan_last;   // fold in last read entry
        logic load;        // append loaded segment
        logic shift;       // one step of the move-up
        logic split;       // write remainder entry
        logic mark;        // write owned entry
        logic free_scan;   // one step of the owner release
        logic free_last;
        logic rewind;      // restart the read at entry 0, keep the hit flag
        logic merge;       // one step of the compaction
        logic merge_last;
        logic flush;       // write the accumulator and set the count
    } dp_cmd_t;

    typedef struct packed {
        logic       full;       // count at capacity
        logic       empty;
        logic       rd_end;     // read pointer reached count
        logic       found;      // a fitting segment was picked
        logic       need_split; // picked size exceeds request
        logic       shift_done;
        logic       owner_hit;
    } dp_stat_t;
endpackage

// ===== hw/rtl/fsa_datapath.sv =====
// Segment table memories, scan and compaction pointers for the allocator.
// Depends on fsa_pkg.
`timescale 1ns / 1ps
module fsa_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  fsa_pkg::dp_cmd_t           cmd,
    input  logic [1:0]                 strategy,
    input  logic [fsa_pkg::ReqW-1:0]   req_size,
    input  logic [fsa_pkg::PidW-1:0]   pid,
    output fsa_pkg::dp_stat_t          stat,
    output logic [fsa_pkg::IdxW-1:0]   pick_idx,
    output logic [fsa_pkg::IdxW-1:0]   load_idx
);
    localparam int IdxW  = fsa_pkg::IdxW;
    localparam int CntW  = fsa_pkg::CntW;
    localparam int SizeW = fsa_pkg::SizeW;
    localparam int PidW  = fsa_pkg::PidW;
    localparam int EntW  = SizeW + 1 + PidW;
    localparam logic [SizeW-1:0] SizeMax = '1;

    // entry: {size, free, owner}
    logic [EntW-1:0] mem [fsa_pkg::MaxSegments];

    logic [CntW-1:0]  count_reg, count_next;
    logic [CntW-1:0]  rd_reg, rd_next;
    logic [CntW-1:0]  wr_reg, wr_next;
    logic [EntW-1:0]  rdata_reg;
    logic [CntW-1:0]  rdidx_reg;     // index of entry held in rdata_reg
    logic             found_reg, found_next, hit_reg, hit_next;
    logic [IdxW-1:0]  pick_reg, pick_next;
    logic [SizeW-1:0] psize_reg, psize_next;
    logic [SizeW-1:0] acc_size_reg, acc_size_next;
    logic             acc_free_reg, acc_free_next;
    logic [PidW-1:0]  acc_own_reg, acc_own_next;
    logic             acc_vld_reg, acc_vld_next;

    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [EntW-1:0]  wdata;
    logic [IdxW-1:0]  raddr;
    logic             re;

    logic [SizeW-1:0] r_size;
    logic             r_free;
    logic [PidW-1:0]  r_own;
    logic [SizeW-1:0] need;
    logic             fits, better;
    logic [SizeW:0]   msum;

    assign r_size = rdata_reg[EntW-1 -: SizeW];
    assign r_free = rdata_reg[PidW];
    assign r_own  = rdata_reg[PidW-1:0];
    assign need   = SizeW'(req_size);
    assign fits   = r_free && (r_size >= need);
    assign msum   = {1'b0, acc_size_reg} + {1'b0, r_size};

    always_comb
    begin
        case (strategy)
            fsa_pkg::STRAT_FIRST: better = !found_reg;
            fsa_pkg::STRAT_BEST:  better = !found_reg || (r_size < psize_reg);
            fsa_pkg::STRAT_WORST: better = !found_reg || (r_size > psize_reg);
            default:              better = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        pick_next     = pick_reg;
        psize_next    = psize_reg;
        acc_size_next = acc_size_reg;
        acc_free_next = acc_free_reg;
        acc_own_next  = acc_own_reg;
        acc_vld_next  = acc_vld_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = rd_reg[IdxW-1:0];
        if (cmd.clr_ptr) begin
            rd_next     = '0;
            wr_next     = '0;
            found_next  = 1'b0;
            hit_next    = 1'b0;
            acc_vld_next = 1'b0;
            re          = 1'b1;
            raddr       = '0;
            rd_next     = CntW'(1);
        end
        if (cmd.rewind) begin
            wr_next      = '0;
            acc_vld_next = 1'b0;
            re           = 1'b1;
            raddr        = '0;
            rd_next      = CntW'(1);
        end
        if (cmd.scan || cmd.scan_last) begin
            if (fits && better) begin
                found_next = 1'b1;
                pick_next  = rdidx_reg[IdxW-1:0];
                psize_next = r_size;
            end
            if (cmd.scan) begin
                re      = 1'b1;
                rd_next = rd_reg + CntW'(1);
            end
        end
        if (cmd.load) begin
            we         = 1'b1;
            waddr      = count_reg[IdxW-1:0];
            wdata      = {need, 1'b1, {PidW{1'b0}}};
            count_next = count_reg + CntW'(1);
        end
        if (cmd.shift) begin
            // move entry at rdidx up by one: read already held in rdata
            we      = 1'b1;
            waddr   = IdxW'(rdidx_reg + CntW'(1));
            wdata   = rdata_reg;
            re      = 1'b1;
            raddr   = IdxW'(rdidx_reg - CntW'(1));
        end
        if (cmd.split) begin
            we         = 1'b1;
            waddr      = pick_reg + IdxW'(1);
            wdata      = {psize_reg - need, 1'b1, {PidW{1'b0}}};
            count_next = count_reg + CntW'(1);
        end
        if (cmd.mark) begin
            we    = 1'b1;
            waddr = pick_reg;
            wdata = {(stat.need_split ? need : psize_reg), 1'b0, pid};
        end
        if (cmd.free_scan || cmd.free_last) begin
            if (!r_free && r_own == pid) begin
                hit_next = 1'b1;
                we       = 1'b1;
                waddr    = rdidx_reg[IdxW-1:0];
                wdata    = {r_size, 1'b1, {PidW{1'b0}}};
            end
            if (cmd.free_scan) begin
                re      = 1'b1;
                rd_next = rd_reg + CntW'(1);
            end
        end
        if (cmd.merge || cmd.merge_last) begin
            if (acc_vld_reg && acc_free_reg && r_free) begin
                acc_size_next = msum[SizeW] ? SizeMax : msum[SizeW-1:0];
            end else begin
                if (acc_vld_reg) begin
                    we      = 1'b1;
                    waddr   = wr_reg[IdxW-1:0];
                    wdata   = {acc_size_reg, acc_free_reg, acc_own_reg};
                    wr_next = wr_reg + CntW'(1);
                end
                acc_size_next = r_size;
                acc_free_next = r_free;
                acc_own_next  = r_own;
                acc_vld_next  = 1'b1;
            end
            if (cmd.merge) begin
                re      = 1'b1;
                rd_next = rd_reg + CntW'(1);
            end
        end
        if (cmd.flush) begin
            we           = 1'b1;
            waddr        = wr_reg[IdxW-1:0];
            wdata        = {acc_size_reg, acc_free_reg, acc_own_reg};
            count_next   = wr_reg + CntW'(1);
            acc_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
            rdidx_reg <= cmd.shift ? rdidx_reg - CntW'(1) : rd_next - CntW'(1);
        end
        pick_reg     <= pick_next;
        psize_reg    <= psize_next;
        acc_size_reg <= acc_size_next;
        acc_free_reg <= acc_free_next;
        acc_own_reg  <= acc_own_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rd_reg      <= '0;
            wr_reg      <= '0;
            found_reg   <= 1'b0;
            hit_reg     <= 1'b0;
            acc_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            found_reg   <= found_next;
            hit_reg     <= hit_next;
            acc_vld_reg <= acc_vld_next;
        end
    end

    assign stat.full       = (count_reg == CntW'(fsa_pkg::MaxSegments));
    assign stat.empty      = (count_reg == '0);
    assign stat.rd_end     = (rd_reg >= count_reg);
    assign stat.found      = found_reg && (strategy != 2'd3);
    assign stat.need_split = (psize_reg > need);
    // done once the entry right after the pick has been moved
    assign stat.shift_done = (rdidx_reg <= CntW'(pick_reg));
    assign stat.owner_hit  = hit_reg;
    assign pick_idx        = pick_reg;
    assign load_idx        = count_reg[IdxW-1:0];
endmodule

// ===== hw/rtl/fsa_ctrl.sv =====
// Controller state machine for the segment allocator: sequences scans,
// move-up, split, release and compaction passes. Depends on fsa_pkg.
`timescale 1ns / 1ps
module fsa_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                op,
    input  fsa_pkg::dp_stat_t         stat,
    input  logic [fsa_pkg::IdxW-1:0]  pick_idx,
    input  logic [fsa_pkg::IdxW-1:0]  load_idx,
    output fsa_pkg::dp_cmd_t          cmd,
    output logic                      busy,
    output logic                      done,
    output logic [1:0]                status,
    output logic [5:0]                segment_index
);
    fsa_pkg::state_t state_reg, state_next;
    logic [1:0]      op_reg;
    logic [1:0]      st_reg, st_next;
    logic [5:0]      idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            fsa_pkg::S_IDLE:
                if (start) state_next = fsa_pkg::S_DISPATCH;
            fsa_pkg::S_DISPATCH:
            begin
                st_next  = fsa_pkg::ST_OK;
                idx_next = '0;
                case (op_reg)
                    fsa_pkg::OP_LOAD:
                    begin
                        state_next = fsa_pkg::S_DONE;
                        if (stat.full) st_next = fsa_pkg::ST_FULL;
                        else idx_next = 6'(load_idx);
                    end
                    fsa_pkg::OP_ALLOC:
                        state_next = stat.empty ? fsa_pkg::S_DECIDE :
                                     (stat.rd_end ? fsa_pkg::S_SCAN_LAST : fsa_pkg::S_SCAN);
                    fsa_pkg::OP_FREE:
                        state_next = stat.empty ? fsa_pkg::S_DONE :
                                     (stat.rd_end ? fsa_pkg::S_FREE_LAST : fsa_pkg::S_FREE_SCAN);
                    default: state_next = fsa_pkg::S_DONE;
                endcase
                if (op_reg == fsa_pkg::OP_FREE && stat.empty) st_next = fsa_pkg::ST_NOOWNER;
            end
            fsa_pkg::S_SCAN:
                if (stat.rd_end) state_next = fsa_pkg::S_SCAN_LAST;
            fsa_pkg::S_SCAN_LAST:
                state_next = fsa_pkg::S_DECIDE;
            fsa_pkg::S_DECIDE:
            begin
                if (!stat.found)
                begin
                    st_next    = fsa_pkg::ST_NOFIT;
                    state_next = fsa_pkg::S_DONE;
                end
                else if (!stat.need_split)
                    state_next = fsa_pkg::S_MARK;
                else if (stat.full)
                begin
                    st_next    = fsa_pkg::ST_FULL;
                    state_next = fsa_pkg::S_DONE;
                end
                else
                    state_next = stat.shift_done ? fsa_pkg::S_SPLIT : fsa_pkg::S_SHIFT;
            end
            fsa_pkg::S_SHIFT:
                if (stat.shift_done) state_next = fsa_pkg::S_SPLIT;
            fsa_pkg::S_SPLIT:
                state_next = fsa_pkg::S_MARK;
            fsa_pkg::S_MARK:
            begin
                idx_next   = 6'(pick_idx);
                state_next = fsa_pkg::S_DONE;
            end
            fsa_pkg::S_FREE_SCAN:
                if (stat.rd_end) state_next = fsa_pkg::S_FREE_LAST;
            fsa_pkg::S_FREE_LAST:
                state_next = fsa_pkg::S_REWIND;
            fsa_pkg::S_REWIND:
                state_next = fsa_pkg::S_MERGE;
            fsa_pkg::S_MERGE:
            begin
                // read restarted in the rewind state; hit decides
                if (!stat.owner_hit)
                begin
                    st_next    = fsa_pkg::ST_NOOWNER;
                    state_next = fsa_pkg::S_DONE;
                end
                else if (stat.rd_end)
                    state_next = fsa_pkg::S_MERGE_LAST;
            end
            fsa_pkg::S_MERGE_LAST:
                state_next = fsa_pkg::S_FLUSH;
            fsa_pkg::S_FLUSH:
                state_next = fsa_pkg::S_DONE;
            fsa_pkg::S_DONE:
                state_next = fsa_pkg::S_IDLE;
            default:
                state_next = fsa_pkg::S_IDLE;
        endcase
    end

    // command decode
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            fsa_pkg::S_IDLE:      cmd.clr_ptr = start;
            fsa_pkg::S_DISPATCH:  cmd.load = (op_reg == fsa_pkg::OP_LOAD) && !stat.full;
            fsa_pkg::S_SCAN:      cmd.scan = !stat.rd_end;
            fsa_pkg::S_SCAN_LAST: cmd.scan_last = 1'b1;
            fsa_pkg::S_DECIDE:    cmd.shift = 1'b0;
            fsa_pkg::S_SHIFT:     cmd.shift = !stat.shift_done;
            fsa_pkg::S_SPLIT:     cmd.split = 1'b1;
            fsa_pkg::S_MARK:      cmd.mark = 1'b1;
            fsa_pkg::S_FREE_SCAN: cmd.free_scan = !stat.rd_end;
            fsa_pkg::S_FREE_LAST: cmd.free_last = 1'b1;
            fsa_pkg::S_REWIND:    cmd.rewind = 1'b1;
            fsa_pkg::S_MERGE:
            begin
                cmd.merge = stat.owner_hit && !stat.rd_end;
            end
            fsa_pkg::S_MERGE_LAST: cmd.merge_last = 1'b1;
            fsa_pkg::S_FLUSH:     cmd.flush = 1'b1;
            fsa_pkg::S_DONE:      cmd.clr_ptr = 1'b0;
            default:              cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsa_pkg::S_IDLE;
            op_reg    <= '0;
            st_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            idx_reg   <= idx_next;
            if (state_reg == fsa_pkg::S_IDLE && start) op_reg <= op;
        end
    end

    assign busy          = (state_reg != fsa_pkg::S_IDLE);
    assign done          = (state_reg == fsa_pkg::S_DONE);
    assign status        = st_reg;
    assign segment_index = idx_reg;
endmodule

// ===== hw/rtl/fit_segment_allocator_top.sv =====
// Top level of the fit segment allocator: controller plus table datapath.
// Depends on fsa_pkg, fsa_ctrl, fsa_datapath.
`timescale 1ns / 1ps
// Usage:
//   Raise start with op, request_size and owner_id while busy is low; the
//   beat is taken at that edge and the fields are captured, so they may
//   change afterwards. busy stays high until the result cycle is over.
//   The single result beat appears on status/segment_index for one cycle
//   with done high; the receiver cannot stall it.
//   strategy_we/strategy_wdata write the fit policy; the user must write it
//   only while idle, as the block itself does not enforce this.
//   An allocate scans the table one entry a cycle through the single read
//   port; a split then moves the entries after the pick up one place and
//   writes the free remainder entry right behind the pick. A deallocate
//   makes a release pass, a rewind and a compaction pass, and ends with no
//   compaction when the owner holds nothing. The next start is taken in
//   the cycle after done.
//   Reset empties the table (count 0) and selects first fit.
module fit_segment_allocator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [15:0] request_size,
    input  logic [15:0] owner_id,
    input  logic        strategy_we,
    input  logic [1:0]  strategy_wdata,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  segment_index
);
    fsa_pkg::dp_cmd_t              cmd;
    fsa_pkg::dp_stat_t             stat;
    logic [fsa_pkg::IdxW-1:0]      pick_idx, load_idx;
    logic [1:0]                    strategy_reg;
    logic [15:0]                   size_reg, pid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= '0;
        end
        else if (strategy_we)
        begin
            strategy_reg <= strategy_wdata;
        end
    end

    // capture the item fields
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            size_reg <= request_size;
            pid_reg  <= owner_id;
        end
    end

    fsa_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .op            (op),
        .stat          (stat),
        .pick_idx      (pick_idx),
        .load_idx      (load_idx),
        .cmd           (cmd),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .segment_index (segment_index)
    );

    fsa_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .strategy (strategy_reg),
        .req_size (size_reg),
        .pid      (pid_reg),
        .stat     (stat),
        .pick_idx (pick_idx),
        .load_idx (load_idx)
    );
endmodule

// ===== tb/tb_top.sv =====
// Testbench for fit_segment_allocator_top: directed and random load, allocate and
// deallocate beats under every fit policy, checked against a segment-table scoreboard.
// Depends on fsa_pkg and the RTL of the allocator.
`timescale 1ns / 1ps
module tb_top;

    localparam int CycleLimit = 2000000;
    localparam int TableDepth = 64;

    class alloc_scoreboard;
        logic [21:0] seg_size [TableDepth];
        bit          seg_free [TableDepth];
        logic [15:0] seg_owner [TableDepth];
        int unsigned seg_count;
        logic [1:0]  fit_policy;
        fsa_pkg::status_t want_status [$];
        logic [5:0]  want_index [$];
        int          errors;

        function new();
            seg_count = 0;
            fit_policy = fsa_pkg::STRAT_FIRST;
            errors = 0;
        endfunction

        function void set_policy(logic [1:0] v);
            fit_policy = v;
        endfunction

        function int pending();
            return want_status.size();
        endfunction

        // size of some table entry, to aim requests at exact fits
        function logic [15:0] some_size();
            if (seg_count == 0)
                return 16'($urandom_range(0, 200));
            return seg_size[$urandom_range(0, seg_count - 1)][15:0];
        endfunction

        function int pick_segment(logic [15:0] need);
            int best;
            best = -1;
            if (fit_policy == 2'd3)
                return -1;
            for (int i = 0; i < seg_count; i++) begin
                if (!seg_free[i] || seg_size[i] < need)
                    continue;
                if (fit_policy == fsa_pkg::STRAT_FIRST)
                    return i;
                if (best < 0 ||
                    (fit_policy == fsa_pkg::STRAT_BEST && seg_size[i] < seg_size[best]) ||
                    (fit_policy == fsa_pkg::STRAT_WORST && seg_size[i] > seg_size[best]))
                    best = i;
            end
            return best;
        endfunction

        function void merge_runs();
            int unsigned w;
            logic [22:0] total;
            w = 0;
            for (int r = 0; r < seg_count; r++) begin
                if (w > 0 && seg_free[w-1] && seg_free[r]) begin
                    total = {1'b0, seg_size[w-1]} + {1'b0, seg_size[r]};
                    seg_size[w-1] = total[22] ? 22'h3FFFFF : total[21:0];
                end else begin
                    seg_size[w] = seg_size[r];
                    seg_free[w] = seg_free[r];
                    seg_owner[w] = seg_owner[r];
                    w++;
                end
            end
            seg_count = w;
        endfunction

        function void push(fsa_pkg::status_t st, int idx);
            want_status.push_back(st);
            want_index.push_back(6'(idx));
        endfunction

        function void note_request(fsa_pkg::op_t o, logic [15:0] sz, logic [15:0] pid);
            int p;
            bit hit;
            case (o)
                fsa_pkg::OP_LOAD: begin
                    if (seg_count >= TableDepth) begin
                        push(fsa_pkg::ST_FULL, 0);
                    end else begin
                        seg_size[seg_count] = 22'(sz);
                        seg_free[seg_count] = 1'b1;
                        seg_owner[seg_count] = '0;
                        push(fsa_pkg::ST_OK, seg_count);
                        seg_count++;
                    end
                end
                fsa_pkg::OP_ALLOC: begin
                    p = pick_segment(sz);
                    if (p < 0) begin
                        push(fsa_pkg::ST_NOFIT, 0);
                    end else if (seg_size[p] > sz && seg_count >= TableDepth) begin
                        push(fsa_pkg::ST_FULL, 0);
                    end else begin
                        if (seg_size[p] > sz) begin
                            // open a slot after the pick for the free remainder
                            for (int i = seg_count; i > p + 1; i--) begin
                                seg_size[i] = seg_size[i-1];
                                seg_free[i] = seg_free[i-1];
                                seg_owner[i] = seg_owner[i-1];
                            end
                            seg_size[p+1] = seg_size[p] - 22'(sz);
                            seg_free[p+1] = 1'b1;
                            seg_owner[p+1] = '0;
                            seg_size[p] = 22'(sz);
                            seg_count++;
                        end
                        seg_free[p] = 1'b0;
                        seg_owner[p] = pid;
                        push(fsa_pkg::ST_OK, p);
                    end
                end
                fsa_pkg::OP_FREE: begin
                    hit = 0;
                    for (int i = 0; i < seg_count; i++) begin
                        if (!seg_free[i] && seg_owner[i] == pid) begin
                            seg_free[i] = 1'b1;
                            seg_owner[i] = '0;
                            hit = 1;
                        end
                    end
                    if (hit) begin
                        merge_runs();
                        push(fsa_pkg::ST_OK, 0);
                    end else begin
                        push(fsa_pkg::ST_NOOWNER, 0);
                    end
                end
                default: push(fsa_pkg::ST_OK, 0);
            endcase
        endfunction

        function void check_reply(logic [1:0] st, logic [5:0] idx);
            fsa_pkg::status_t es;
            logic [5:0] ei;
            if (want_status.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: status %0d index %0d", st, idx);
                return;
            end
            es = want_status.pop_front();
            ei = want_index.pop_front();
            if (st !== es || idx !== ei) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected status %0d index %0d, got %0d %0d",
                             es, ei, st, idx);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [15:0] request_size;
    logic [15:0] owner_id;
    logic        strategy_we;
    logic [1:0]  strategy_wdata;
    logic        done;
    logic [1:0]  status;
    logic [5:0]  segment_index;

    alloc_scoreboard sb = new();
    int  cycles = 0;
    bit  gaps_on;

    fit_segment_allocator_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .request_size(request_size), .owner_id(owner_id),
        .strategy_we(strategy_we), .strategy_wdata(strategy_wdata),
        .done(done), .status(status), .segment_index(segment_index)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply(status, segment_index);
    end

    task automatic send_item(input fsa_pkg::op_t o, input logic [15:0] sz,
                             input logic [15:0] pid);
        if (gaps_on && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 17)) @(posedge clk);
        op <= o;
        request_size <= sz;
        owner_id <= pid;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_request(o, sz, pid);
        start <= 1'b0;
        // hold the fields until the reply is back
        while (sb.pending() > 0) @(posedge clk);
    endtask

    task automatic write_policy(input logic [1:0] v);
        strategy_we <= 1'b1;
        strategy_wdata <= v;
        @(posedge clk);
        strategy_we <= 1'b0;
        sb.set_policy(v);
        repeat (3) @(posedge clk);
    endtask

    task automatic random_item();
        int roll;
        logic [15:0] sz;
        logic [15:0] pid;
        roll = $urandom_range(0, 99);
        pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        if (roll < 30) begin
            sz = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
            send_item(fsa_pkg::OP_LOAD, sz, pid);
        end else if (roll < 72) begin
            case ($urandom_range(0, 4))
                0, 1: sz = sb.some_size();
                2, 3: sz = 16'($urandom_range(0, 300));
                default: sz = 16'($urandom);
            endcase
            send_item(fsa_pkg::OP_ALLOC, sz, pid);
        end else if (roll < 96) begin
            send_item(fsa_pkg::OP_FREE, 16'($urandom), pid);
        end else begin
            send_item(fsa_pkg::OP_NONE, 16'($urandom), pid);
        end
    endtask

    initial
    begin
        logic [1:0] policies [7];
        int         counts [7];
        int         done_items;
        policies = '{fsa_pkg::STRAT_BEST, fsa_pkg::STRAT_WORST, fsa_pkg::STRAT_FIRST, 2'd3,
                     fsa_pkg::STRAT_WORST, fsa_pkg::STRAT_BEST, fsa_pkg::STRAT_FIRST};
        counts = '{330, 330, 330, 40, 330, 280, 260};
        rst_n = 1'b0;
        start = 1'b0;
        op = fsa_pkg::OP_LOAD;
        request_size = '0;
        owner_id = '0;
        strategy_we = 1'b0;
        strategy_wdata = '0;
        gaps_on = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_policy(fsa_pkg::STRAT_FIRST);
        send_item(fsa_pkg::OP_LOAD, 16'd0, 16'd0);
        send_item(fsa_pkg::OP_LOAD, 16'hFFFF, 16'd0);
        send_item(fsa_pkg::OP_LOAD, 16'd100, 16'd0);
        send_item(fsa_pkg::OP_LOAD, 16'd50, 16'd0);
        send_item(fsa_pkg::OP_ALLOC, 16'hFFFF, 16'd1);      // exact fit
        send_item(fsa_pkg::OP_ALLOC, 16'd0, 16'd2);         // zero size
        send_item(fsa_pkg::OP_ALLOC, 16'd30, 16'hFFFF);     // split
        send_item(fsa_pkg::OP_ALLOC, 16'hFFFF, 16'd3);      // nothing fits
        send_item(fsa_pkg::OP_FREE, 16'd0, 16'd9);          // unknown owner
        send_item(fsa_pkg::OP_NONE, 16'hFFFF, 16'hFFFF);
        send_item(fsa_pkg::OP_FREE, 16'd0, 16'd1);
        send_item(fsa_pkg::OP_FREE, 16'hFFFF, 16'hFFFF);
        send_item(fsa_pkg::OP_FREE, 16'd0, 16'd2);
        write_policy(2'd3);
        send_item(fsa_pkg::OP_ALLOC, 16'd10, 16'd4);
        write_policy(fsa_pkg::STRAT_BEST);
        send_item(fsa_pkg::OP_ALLOC, 16'd40, 16'd5);
        write_policy(fsa_pkg::STRAT_WORST);
        send_item(fsa_pkg::OP_ALLOC, 16'd40, 16'd6);

        done_items = 0;
        foreach (policies[p]) begin
            write_policy(policies[p]);
            for (int n = 0; n < counts[p]; n++) begin
                // run the tail without gaps
                gaps_on = (done_items < 1600);
                random_item();
                done_items++;
            end
        end

        while (sb.pending() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
